FILE: sv/hsv_rgb_led_bit_encoder_core_defines.svh
// assertion macros shared by the encoder core
`ifndef HSV_RGB_LED_BIT_ENCODER_CORE_DEFINES_SVH
`define HSV_RGB_LED_BIT_ENCODER_CORE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define HRLBE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hrlbe assertion failed");

// next-cycle implication, quiet during reset
`define HRLBE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hrlbe assertion failed");

// next-cycle implication that also covers reset itself
`define HRLBE_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("hrlbe assertion failed");

`endif

FILE: sv/hrlbe_pkg.sv
`default_nettype none

package hrlbe_pkg;

   // item codes
   localparam logic OP_COLOR = 1'b0;
   localparam logic OP_HUE   = 1'b1;

   // hue wheel and scaling constants
   localparam int unsigned HUE_SPAN   = 1530;
   localparam int unsigned HUE_ROUND  = 32768;
   localparam int unsigned HUE_W      = 11;
   localparam int unsigned HUE_PROD_W = 27;
   localparam logic [7:0]  BRIGHTNESS_RESET = 8'd200;
   localparam logic [3:0]  NIB_ONE  = 4'hE;
   localparam logic [3:0]  NIB_ZERO = 4'h8;

   typedef struct packed {
      logic        op;
      logic [23:0] color;
      logic [15:0] hue;
      logic [7:0]  value;
   } req_word_type;

   typedef struct packed {
      logic [31:0] green_word;
      logic [31:0] red_word;
      logic [31:0] blue_word;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } rgb_type;

   // nibble coding of one level, 16-bit halves swapped
   function automatic logic [31:0] code_level(input logic [7:0] level);
      logic [31:0] w;
      w = '0;
      for (int i = 0; i < 8; i++) begin
         w[4*i +: 4] = level[i] ? NIB_ONE : NIB_ZERO;
      end
      return {w[15:0], w[31:16]};
   endfunction

endpackage

`default_nettype wire

FILE: sv/hrlbe_div255.sv
`default_nettype none

// floor(x / 255) for x up to 255*255, by reciprocal add and shift
module hrlbe_div255 (
   input  wire logic [15:0] dividend,
   output logic      [7:0]  quotient
);

   logic [16:0] plus_one;
   logic [16:0] sum;

   always_comb begin
      plus_one = {1'b0, dividend} + 17'd1;
      sum      = plus_one + {8'd0, plus_one[16:8]};
      quotient = sum[15:8];
   end

endmodule

`default_nettype wire

FILE: sv/hrlbe_hue_map.sv
`default_nettype none

// wheel position 0..1530 to a fully saturated hexcone point
module hrlbe_hue_map (
   input  wire logic [hrlbe_pkg::HUE_W-1:0] hue_pos,
   output hrlbe_pkg::rgb_type                rgb
);

   localparam logic [hrlbe_pkg::HUE_W-1:0] P255  = 11'd255;
   localparam logic [hrlbe_pkg::HUE_W-1:0] P510  = 11'd510;
   localparam logic [hrlbe_pkg::HUE_W-1:0] P765  = 11'd765;
   localparam logic [hrlbe_pkg::HUE_W-1:0] P1020 = 11'd1020;
   localparam logic [hrlbe_pkg::HUE_W-1:0] P1275 = 11'd1275;
   localparam logic [hrlbe_pkg::HUE_W-1:0] P1530 = 11'd1530;

   logic [hrlbe_pkg::HUE_W-1:0] rise;
   logic [hrlbe_pkg::HUE_W-1:0] fall;

   always_comb begin
      rgb  = '0;
      rise = '0;
      fall = '0;
      if (hue_pos < P510) begin
         // red to yellow to green
         if (hue_pos < P255) begin
            rgb.r = 8'hFF;
            rgb.g = hue_pos[7:0];
         end else begin
            fall  = P510 - hue_pos;
            rgb.r = fall[7:0];
            rgb.g = 8'hFF;
         end
      end else if (hue_pos < P1020) begin
         // green to cyan to blue
         if (hue_pos < P765) begin
            rise  = hue_pos - P510;
            rgb.g = 8'hFF;
            rgb.b = rise[7:0];
         end else begin
            fall  = P1020 - hue_pos;
            rgb.g = fall[7:0];
            rgb.b = 8'hFF;
         end
      end else if (hue_pos < P1530) begin
         // blue to magenta to red
         if (hue_pos < P1275) begin
            rise  = hue_pos - P1020;
            rgb.r = rise[7:0];
            rgb.b = 8'hFF;
         end else begin
            fall  = P1530 - hue_pos;
            rgb.r = 8'hFF;
            rgb.b = fall[7:0];
         end
      end else begin
         // top of the wheel folds back to pure red
         rgb.r = 8'hFF;
      end
   end

endmodule

`default_nettype wire

FILE: sv/hsv_rgb_led_bit_encoder_core.sv
// Color to serial LED word encoder.
// req channel (valid/ready): one word holds op, a packed RGB color, a 16-bit
// hue and a per-item value. op color uses the color field, op hue maps the
// hue onto the color wheel. Each channel is scaled by value/255, then by the
// brightness register/255, and coded as a 32-bit nibble word.
// rsp channel (valid/ready): green, red and blue words of that item, in order.
// csr port: csr_we with csr_wdata writes brightness at once; write it only
// while no word is in flight.
// Path: a word accepted into the stage 1 register moves through stages 2 to
// 6 in order and shows on rsp from the stage 6 register until it is taken.
// Throughput: one word per cycle while rsp_ready is high, through six register
// stages (hue multiply, hexcone, value multiply, divide, brightness multiply,
// divide and coding). Each stage holds its word while the next one is full, so a
// stalled rsp side fills the stages one by one and req_ready falls only when all
// six are full; nothing is lost or repeated.
// Reset: synchronous; empties every stage and sets brightness to 200.
`default_nettype none

module hsv_rgb_led_bit_encoder_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire hrlbe_pkg::req_word_type req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output hrlbe_pkg::rsp_word_type      rsp_data,
   input  wire logic                    csr_we,
   input  wire logic [7:0]              csr_wdata
);

`include "hsv_rgb_led_bit_encoder_core_defines.svh"

   // brightness register
   logic [7:0] bright_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff <= hrlbe_pkg::BRIGHTNESS_RESET;
      end else if (csr_we) begin
         bright_ff <= csr_wdata;
      end
   end

   // stage valid bits and per-stage advance
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic go1, go2, go3, go4, go5, go6;

   always_comb begin
      go6       = !v6_ff || rsp_ready;
      go5       = !v5_ff || go6;
      go4       = !v4_ff || go5;
      go3       = !v3_ff || go4;
      go2       = !v2_ff || go3;
      go1       = !v1_ff || go2;
      req_ready = go1;
      rsp_valid = v6_ff;
   end

   // stage 1: hue times wheel span, rounded
   logic [hrlbe_pkg::HUE_PROD_W-1:0] hue_prod;
   logic [hrlbe_pkg::HUE_W-1:0]      s1_hue_in, s1_hue_ff;
   logic                             s1_op_ff;
   logic [23:0]                      s1_color_ff;
   logic [7:0]                       s1_value_ff;

   always_comb begin
      hue_prod = {11'd0, req_data.hue} * hrlbe_pkg::HUE_SPAN[10:0]
               + hrlbe_pkg::HUE_ROUND[hrlbe_pkg::HUE_PROD_W-1:0];
      s1_hue_in = hue_prod[hrlbe_pkg::HUE_PROD_W-1:16];
   end

   always_ff @(posedge clock) begin
      if (go1) begin
         s1_hue_ff   <= s1_hue_in;
         s1_op_ff    <= req_data.op;
         s1_color_ff <= req_data.color;
         s1_value_ff <= req_data.value;
      end
   end

   // stage 2: hexcone point or packed color
   hrlbe_pkg::rgb_type wheel_rgb;
   hrlbe_pkg::rgb_type s2_rgb_in, s2_rgb_ff;
   logic [7:0]         s2_value_ff;

   hrlbe_hue_map u_hue_map (
      .hue_pos (s1_hue_ff),
      .rgb     (wheel_rgb)
   );

   always_comb begin
      if (s1_op_ff == hrlbe_pkg::OP_HUE) begin
         s2_rgb_in = wheel_rgb;
      end else begin
         s2_rgb_in.r = s1_color_ff[23:16];
         s2_rgb_in.g = s1_color_ff[15:8];
         s2_rgb_in.b = s1_color_ff[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (go2) begin
         s2_rgb_ff   <= s2_rgb_in;
         s2_value_ff <= s1_value_ff;
      end
   end

   // stage 3: scale by value
   logic [15:0] s3_r_ff, s3_g_ff, s3_b_ff;

   always_ff @(posedge clock) begin
      if (go3) begin
         s3_r_ff <= {8'd0, s2_rgb_ff.r} * {8'd0, s2_value_ff};
         s3_g_ff <= {8'd0, s2_rgb_ff.g} * {8'd0, s2_value_ff};
         s3_b_ff <= {8'd0, s2_rgb_ff.b} * {8'd0, s2_value_ff};
      end
   end

   // stage 4: first divide by 255
   hrlbe_pkg::rgb_type s4_rgb_in, s4_rgb_ff;

   hrlbe_div255 u_div_r1 (.dividend(s3_r_ff), .quotient(s4_rgb_in.r));
   hrlbe_div255 u_div_g1 (.dividend(s3_g_ff), .quotient(s4_rgb_in.g));
   hrlbe_div255 u_div_b1 (.dividend(s3_b_ff), .quotient(s4_rgb_in.b));

   always_ff @(posedge clock) begin
      if (go4) begin
         s4_rgb_ff <= s4_rgb_in;
      end
   end

   // stage 5: scale by brightness
   logic [15:0] s5_r_ff, s5_g_ff, s5_b_ff;

   always_ff @(posedge clock) begin
      if (go5) begin
         s5_r_ff <= {8'd0, s4_rgb_ff.r} * {8'd0, bright_ff};
         s5_g_ff <= {8'd0, s4_rgb_ff.g} * {8'd0, bright_ff};
         s5_b_ff <= {8'd0, s4_rgb_ff.b} * {8'd0, bright_ff};
      end
   end

   // stage 6: second divide by 255 and nibble coding into the output register
   hrlbe_pkg::rgb_type      lvl;
   hrlbe_pkg::rsp_word_type s6_word_in, s6_word_ff;

   hrlbe_div255 u_div_r2 (.dividend(s5_r_ff), .quotient(lvl.r));
   hrlbe_div255 u_div_g2 (.dividend(s5_g_ff), .quotient(lvl.g));
   hrlbe_div255 u_div_b2 (.dividend(s5_b_ff), .quotient(lvl.b));

   always_comb begin
      s6_word_in.green_word = hrlbe_pkg::code_level(lvl.g);
      s6_word_in.red_word   = hrlbe_pkg::code_level(lvl.r);
      s6_word_in.blue_word  = hrlbe_pkg::code_level(lvl.b);
      rsp_data              = s6_word_ff;
   end

   always_ff @(posedge clock) begin
      if (go6) begin
         s6_word_ff <= s6_word_in;
      end
   end

   // valid bits move with their stage
   logic v1_in, v2_in, v3_in, v4_in, v5_in, v6_in;

   always_comb begin
      v1_in = go1 ? req_valid : v1_ff;
      v2_in = go2 ? v1_ff     : v2_ff;
      v3_in = go3 ? v2_ff     : v3_ff;
      v4_in = go4 ? v3_ff     : v4_ff;
      v5_in = go5 ? v4_ff     : v5_ff;
      v6_in = go6 ? v5_ff     : v6_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
         v6_ff <= v6_in;
      end
   end

   // terms used by the checks
   logic all_full, s3_zero, idle_state;

   always_comb begin
      all_full   = v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && v6_ff;
      s3_zero    = (s3_r_ff == 16'd0) && (s3_g_ff == 16'd0) && (s3_b_ff == 16'd0);
      idle_state = (bright_ff == hrlbe_pkg::BRIGHTNESS_RESET) && !rsp_valid;
   end

   // checks
   `HRLBE_ASSERT_SAME(a_ready_low_means_full, !req_ready, all_full)
   `HRLBE_ASSERT_NEXT(a_last_stage_moves, v5_ff && go6, rsp_valid)
   `HRLBE_ASSERT_NEXT(a_zero_value_zero_level, v2_ff && go3 && s2_value_ff == 8'd0, s3_zero)
   `HRLBE_ASSERT_NEXT_ALWAYS(a_reset_brightness, reset, idle_state)

endmodule

`default_nettype wire
